FILE: src/gtp_pkg.sv
package gtp_pkg;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] drive_one;
      logic signed [15:0] drive_two;
      logic               arrived;
   } rsp_word_type;

   localparam int CORDIC_STEPS = 16;
   localparam logic signed [19:0] PI_Q13     = 20'sd25736;
   localparam logic signed [19:0] TWO_PI_Q13 = 20'sd51472;
   localparam logic signed [19:0] PI20_Q13   = 20'sd1287;
   localparam logic signed [20:0] HALFPI_Q16 = 21'sd102944;
   localparam logic [33:0] FOUR_M_Q16  = 34'd262144;
   localparam logic [33:0] QUARTER_Q16 = 34'd16384;

   localparam logic [2:0] REG_TARGET_X  = 3'd0;
   localparam logic [2:0] REG_TARGET_Y  = 3'd1;
   localparam logic [2:0] REG_TARGET_H  = 3'd2;
   localparam logic [2:0] REG_GAIN_DIST = 3'd3;
   localparam logic [2:0] REG_GAIN_BEAR = 3'd4;
   localparam logic [2:0] REG_GAIN_FIN  = 3'd5;
   localparam logic [2:0] REG_THRESHOLD = 3'd6;

   function automatic logic [16:0] atan_entry(input logic [3:0] i);
      logic [16:0] r;
      case (i)
         4'd0:  r = 17'd51472;
         4'd1:  r = 17'd30386;
         4'd2:  r = 17'd16055;
         4'd3:  r = 17'd8150;
         4'd4:  r = 17'd4091;
         4'd5:  r = 17'd2047;
         4'd6:  r = 17'd1024;
         4'd7:  r = 17'd512;
         4'd8:  r = 17'd256;
         4'd9:  r = 17'd128;
         4'd10: r = 17'd64;
         4'd11: r = 17'd32;
         4'd12: r = 17'd16;
         4'd13: r = 17'd8;
         4'd14: r = 17'd4;
         default: r = 17'd2;
      endcase
      return r;
   endfunction

   // Wraps an angle known to lie in (-5*pi, 5*pi] into (-pi, pi].
   function automatic logic signed [19:0] wrap_ang(input logic signed [19:0] a);
      logic signed [19:0] r;
      r = a;
      if (r > PI_Q13) r = r - TWO_PI_Q13;
      if (r > PI_Q13) r = r - TWO_PI_Q13;
      if (r <= -PI_Q13) r = r + TWO_PI_Q13;
      if (r <= -PI_Q13) r = r + TWO_PI_Q13;
      return r;
   endfunction

endpackage

FILE: src/go_to_pose_drive_controller_core.sv
// Go-to-pose drive controller for a two-wheeled base.
// Each word on the req_ channel is one odometry pose (x, y, heading). The
// block answers with at most one word on the rsp_ channel: a pair of wheel
// commands, or on arrival a single zero command with arrived set. After the
// arrival word it stays silent at the goal until a write to csr_index 0-6 re-arms it.
// The csr_ port is a plain write port; write only while the block is idle.
// The bearing CORDIC (16 iterations) and the bit-serial square root
// (32 iterations) are loaded in the cycle after the pose is taken and run
// side by side; S_DECIDE forms the angle errors, the shared multiplier takes
// four products one per cycle in S_MUL, then S_OUT saturates and forms the
// result. req_ready is low meanwhile, and no new pose is taken until the
// block is through with the last one.
// If the receiver stalls, the result waits in the output register and no new
// pose is taken until it has gone.
// Reset (synchronous, active high) loads the register defaults and arms the
// block; no clearing pass is needed.
module go_to_pose_drive_controller_core
   import gtp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   typedef enum logic [2:0] {
      S_IDLE, S_SOLVE, S_DECIDE, S_MUL, S_OUT, S_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic signed [31:0] tx_ff, ty_ff;
   logic signed [15:0] th_ff;
   logic [15:0] gd_ff, gb_ff, gf_ff;
   logic [31:0] thr_ff;
   logic armed_ff, armed_in;

   logic signed [32:0] dx_ff, dy_ff;
   logic signed [15:0] head_ff;
   logic shift_ff;
   logic cordic_done, sqrt_done, cdone_ff, sdone_ff;
   logic signed [19:0] angle, bear_ff;
   logic [31:0] root;
   logic [32:0] dist_ff;
   logic signed [19:0] dang_ff, dcmd_ff, dth_ff;
   logic [1:0] mstep_ff;
   logic signed [60:0] acc_ff, acc_in, fwd_ff, fwd_in;
   logic signed [60:0] prod;
   logic signed [34:0] ma;
   logic signed [20:0] mb;
   logic stop_ff;
   logic dsq_far_ff;
   rsp_word_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [32:0] ax, ay, axs, ay2;
   logic big;
   logic [63:0] radicand;
   logic start;

   assign start = req_valid && req_ready;

   always_comb begin
      ax = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      ay = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      big = ax[32] | ax[31] | ay[32] | ay[31];
      axs = big ? ax >> 1 : ax;
      ay2 = big ? ay >> 1 : ay;
      radicand = 64'(axs[31:0]) * 64'(axs[31:0]) + 64'(ay2[31:0]) * 64'(ay2[31:0]);
   end

   // The first cycle in S_SOLVE loads both iterative units.
   logic launch_ff;
   gtp_cordic u_cordic (
      .clock(clock), .reset(reset), .start(launch_ff),
      .dx(dx_ff), .dy(dy_ff), .done(cordic_done), .angle(angle));
   gtp_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(launch_ff),
      .radicand(radicand), .done(sqrt_done), .root(root));

   // Shared multiplier: one product a cycle.
   always_comb begin
      case (mstep_ff)
         2'd0: begin ma = 35'(dth_ff); mb = 21'(dth_ff); end
         2'd1: begin ma = 35'(stop_ff ? 33'd0 : dist_ff) + 35'(QUARTER_Q16);
                     mb = 21'($signed({1'b0, gd_ff})); end
         2'd2: begin ma = 35'(dang_ff); mb = 21'($signed({1'b0, gb_ff})); end
         default: begin ma = stop_ff ? 35'sd0 : 35'(dcmd_ff);
                        mb = 21'($signed({1'b0, gf_ff})); end
      endcase
      prod = 61'(ma) * 61'(mb);
   end

   function automatic logic signed [15:0] to_out(input logic signed [60:0] v);
      logic signed [60:0] m, r;
      m = v[60] ? -v : v;
      r = m >>> 24;
      if (v[60]) r = -r;
      if (r > 61'sd32767) return 16'sh7FFF;
      if (r < -61'sd32768) return 16'sh8000;
      return r[15:0];
   endfunction

   logic [63:0] dsq;
   logic dsq_far;
   logic signed [60:0] turn8;
   assign dsq = 64'(acc_ff[39:0]) * 64'd100;
   assign dsq_far = dsq > {22'd0, thr_ff, 10'd0};
   assign turn8 = acc_ff <<< 3;

   always_comb begin
      state_in = state_ff; acc_in = acc_ff; fwd_in = fwd_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff; armed_in = armed_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (csr_write && csr_index <= REG_THRESHOLD) armed_in = 1'b1;
      case (state_ff)
         S_IDLE:   if (start) state_in = S_SOLVE;
         S_SOLVE:  if ((cdone_ff || cordic_done) && (sdone_ff || sqrt_done))
                      state_in = S_DECIDE;
         S_DECIDE: state_in = S_MUL;
         S_MUL: begin
            case (mstep_ff)
               2'd0: acc_in = prod;
               2'd1: fwd_in = prod;
               2'd2: acc_in = prod;
               default: begin acc_in = acc_ff + prod; state_in = S_OUT; end
            endcase
         end
         S_OUT: begin
            state_in = S_HOLD;
            rsp_in.drive_one = to_out(fwd_ff + turn8);
            rsp_in.drive_two = to_out(fwd_ff - turn8);
            rsp_in.arrived = 1'b0;
            if (!dsq_far_ff && dist_ff <= {1'b0, thr_ff}) begin
               rsp_in = '0;
               if (armed_ff) begin
                  armed_in = 1'b0; rsp_in.arrived = 1'b1; rsp_valid_in = 1'b1;
               end
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         S_HOLD: if (!rsp_valid_in) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; armed_ff <= 1'b1;
         tx_ff <= '0; ty_ff <= '0; th_ff <= '0;
         gd_ff <= 16'd256; gb_ff <= 16'd256; gf_ff <= '0; thr_ff <= 32'd6554;
         launch_ff <= 1'b0; cdone_ff <= 1'b0; sdone_ff <= 1'b0; mstep_ff <= '0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in; armed_ff <= armed_in;
         launch_ff <= start;
         if (csr_write) begin
            case (csr_index)
               REG_TARGET_X:  tx_ff <= csr_data;
               REG_TARGET_Y:  ty_ff <= csr_data;
               REG_TARGET_H:  th_ff <= csr_data[15:0];
               REG_GAIN_DIST: gd_ff <= csr_data[15:0];
               REG_GAIN_BEAR: gb_ff <= csr_data[15:0];
               REG_GAIN_FIN:  gf_ff <= csr_data[15:0];
               REG_THRESHOLD: thr_ff <= csr_data;
               default: ;
            endcase
         end
         if (start) begin
            cdone_ff <= 1'b0; sdone_ff <= 1'b0;
         end else begin
            if (cordic_done) cdone_ff <= 1'b1;
            if (sqrt_done) sdone_ff <= 1'b1;
         end
         if (state_ff == S_MUL) mstep_ff <= mstep_ff + 2'd1;
         else mstep_ff <= '0;
      end
      if (start) begin
         dx_ff <= 33'(tx_ff) - 33'(req_data.pos_x);
         dy_ff <= 33'(ty_ff) - 33'(req_data.pos_y);
         head_ff <= req_data.heading;
         shift_ff <= 1'b0;
      end
      if (launch_ff) shift_ff <= big;
      if (cordic_done) bear_ff <= angle;
      if (sqrt_done) dist_ff <= shift_ff ? {root, 1'b0} : {1'b0, root};
      if (state_ff == S_DECIDE) begin
         dang_ff <= wrap_ang(bear_ff - 20'(head_ff));
         dcmd_ff <= wrap_ang(bear_ff - 20'(th_ff));
         dth_ff  <= wrap_ang(20'(head_ff) - 20'(th_ff));
         stop_ff <= 1'b0;
      end
      if (state_ff == S_MUL && mstep_ff == 2'd0) begin
         stop_ff <= (dist_ff > FOUR_M_Q16[32:0]) &&
                    (dang_ff > PI20_Q13 || dang_ff < -PI20_Q13);
      end
      if (state_ff == S_MUL && mstep_ff == 2'd1) dsq_far_ff <= dsq_far;
      acc_ff <= acc_in; fwd_ff <= fwd_in; rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

FILE: src/gtp_cordic.sv
module gtp_cordic
   import gtp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] dx,
   input  logic signed [32:0] dy,
   output logic               done,
   output logic signed [19:0] angle
);
   // x and y carry the 2^24 scale implicitly: the shifts keep full precision.
   logic signed [60:0] x_ff, x_in, y_ff, y_in;
   logic signed [21:0] z_ff, z_in;
   logic [3:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in, zero_ff, zero_in;
   logic signed [60:0] xs, ys, sx, sy;
   logic signed [21:0] zr;

   assign sx = 61'(dx) <<< 24;
   assign sy = 61'(dy) <<< 24;
   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign zr = (z_ff + 22'sd4) >>> 3;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; step_in = step_ff;
      busy_in = busy_ff; done_in = 1'b0; zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1; step_in = '0;
         zero_in = (dx == 33'sd0) && (dy == 33'sd0);
         if (dx < 0) begin
            if (dy >= 0) begin
               x_in = sy; y_in = -sx; z_in = 22'(HALFPI_Q16);
            end else begin
               x_in = -sy; y_in = sx; z_in = -22'(HALFPI_Q16);
            end
         end else begin
            x_in = sx; y_in = sy; z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + 22'(atan_entry(step_ff));
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - 22'(atan_entry(step_ff));
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; step_ff <= '0; zero_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; step_ff <= step_in; zero_ff <= zero_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
   end

   assign done  = done_ff;
   assign angle = zero_ff ? 20'sd0 : wrap_ang(20'(zr));
endmodule

FILE: src/gtp_isqrt.sv
module gtp_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] n_ff, n_in, res_ff, res_in, bit_ff, bit_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      n_in = n_ff; res_in = res_ff; bit_in = bit_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         n_in = radicand; res_in = '0; bit_in = 64'd1 << 62; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in = n_ff - trial; res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      n_ff <= n_in; res_ff <= res_in; bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];
endmodule

FILE: verif/tb_go_to_pose_drive_controller_core.sv
module tb_go_to_pose_drive_controller_core;
   import gtp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 80;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef struct {
      req_word_type pose;
      bit           typed;
      bit           has_word;
      rsp_word_type word;
   } pose_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   logic         csr_write;
   logic [2:0]   csr_index;
   logic [31:0]  csr_data;

   // Shadow copy of the goal, gains and arming state.
   longint goal_x, goal_y, goal_heading;
   longint k_dist, k_bearing, k_final, arrive_thr;
   bit     is_armed;

   rsp_word_type drive_queue[$];
   int  fail_count = 0;
   int  idle_cycles;
   bit  rx_steady;

   go_to_pose_drive_controller_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint wrap_angle(input longint a);
      longint r;
      r = a;
      while (r > 25736) r = r - 51472;
      while (r <= -25736) r = r + 51472;
      return r;
   endfunction

   function automatic longint bearing_to_goal(input longint dx, input longint dy);
      longint x, y, z, t, xs, ys;
      longint steps[16];
      steps = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
      if (dx == 0 && dy == 0) return 0;
      x = dx * (64'sd1 << 24);
      y = dy * (64'sd1 << 24);
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 102944;
         end else begin
            x = -y; y = t; z = -102944;
         end
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + steps[i];
         end else begin
            x = x - ys; y = y + xs; z = z - steps[i];
         end
      end
      return wrap_angle((z + 4) >>> 3);
   endfunction

   function automatic longint unsigned goal_distance(input longint dx, input longint dy);
      longint unsigned ax, ay, n, root, b;
      int sh;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sh = (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) ? 1 : 0;
      ax = ax >> sh;
      ay = ay >> sh;
      n = ax * ax + ay * ay;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root << sh;
   endfunction

   function automatic logic signed [15:0] wheel_command(input longint v);
      longint r;
      r = (v >= 0) ? (v >>> 24) : -((-v) >>> 24);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // Works out the wheel word for one pose; returns 0 when the block stays silent.
   function automatic bit drive_for_pose(input req_word_type p, output rsp_word_type w);
      longint dx, dy, th, b, head_err, diff_cmd, dtheta, fwd, turn;
      longint unsigned goal_range, dsq;
      th = longint'(p.heading);
      dx = goal_x - longint'(p.pos_x);
      dy = goal_y - longint'(p.pos_y);
      b = bearing_to_goal(dx, dy);
      head_err = wrap_angle(b - th);
      diff_cmd = wrap_angle(b - goal_heading);
      dtheta = wrap_angle(th - goal_heading);
      goal_range = goal_distance(dx, dy);
      dsq = dtheta * dtheta * 100;
      w = '0;
      if (dsq > (longint'(arrive_thr) << 10) || goal_range > arrive_thr) begin
         if (goal_range > 262144 && (head_err > 1287 || head_err < -1287)) begin
            goal_range = 0;
            diff_cmd = 0;
         end
         fwd = k_dist * longint'(goal_range + 16384);
         turn = (k_bearing * head_err + k_final * diff_cmd) * 8;
         w.drive_one = wheel_command(fwd + turn);
         w.drive_two = wheel_command(fwd - turn);
         return 1'b1;
      end
      if (is_armed) begin
         is_armed = 1'b0;
         w.arrived = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         REG_TARGET_X:  goal_x = longint'(signed'(value));
         REG_TARGET_Y:  goal_y = longint'(signed'(value));
         REG_TARGET_H:  goal_heading = longint'(signed'(value[15:0]));
         REG_GAIN_DIST: k_dist = value[15:0];
         REG_GAIN_BEAR: k_bearing = value[15:0];
         REG_GAIN_FIN:  k_final = value[15:0];
         REG_THRESHOLD: arrive_thr = value;
         default: ;
      endcase
      if (idx != REG_UNUSED) is_armed = 1'b1;
   endtask

   // Called at a falling edge; returns at a falling edge after the word is taken.
   task automatic send_pose(input pose_row_type row);
      rsp_word_type w;
      bit has;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick >= 70 && pick < 92) repeat ($urandom_range(1, 4)) @(negedge clock);
      else if (pick >= 92) repeat ($urandom_range(20, 150)) @(negedge clock);
      req_valid = 1'b1;
      req_data = row.pose;
      do @(posedge clock); while (!req_ready);
      has = drive_for_pose(row.pose, w);
      if (row.typed) begin
         has = row.has_word;
         w = row.word;
      end
      if (has) drive_queue.push_back(w);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (drive_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_heading();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 16'($urandom());
      if (pick == 1) return ($urandom_range(0, 1) == 1) ? 16'sd25736 : -16'sd25736;
      return 16'($urandom_range(0, 51472) - 25736);
   endfunction

   function automatic req_word_type rand_pose(input int phase);
      req_word_type p;
      int pick;
      longint span;
      pick = $urandom_range(0, 99);
      span = (phase % 2) ? 64'd600000 : 64'd8000;
      if (pick < 55) begin
         // Close to the goal, around the arrival and four-metre boundaries.
         p.pos_x = 32'(goal_x + $urandom_range(0, 2 * span) - span);
         p.pos_y = 32'(goal_y + $urandom_range(0, 2 * span) - span);
         p.heading = (pick < 35) ? 16'(goal_heading + $urandom_range(0, 40) - 20)
                                 : rand_heading();
      end else if (pick < 65) begin
         p.pos_x = 32'(goal_x);
         p.pos_y = 32'(goal_y + $urandom_range(0, 4) - 2);
         p.heading = 16'(goal_heading);
      end else begin
         p.pos_x = $urandom();
         p.pos_y = $urandom();
         p.heading = rand_heading();
      end
      return p;
   endfunction

   initial begin
      pose_row_type rows[$];
      pose_row_type row;
      logic [31:0] thr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = REG_TARGET_X;
      csr_data = '0;
      goal_x = 0; goal_y = 0; goal_heading = 0;
      k_dist = 256; k_bearing = 256; k_final = 0; arrive_thr = 6554;
      is_armed = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Pose at the goal gives the stop word once, then silence.
      row.typed = 1'b1;
      row.has_word = 1'b1;
      row.word = '{drive_one: 16'sd0, drive_two: 16'sd0, arrived: 1'b1};
      row.pose = '{pos_x: 32'sd0, pos_y: 32'sd0, heading: 16'sd0};
      rows.push_back(row);
      row.has_word = 1'b0;
      rows.push_back(row);
      row.typed = 1'b0;
      row.pose = '{32'sd0, 32'sd0, 16'sd100};          rows.push_back(row);
      row.pose = '{32'sd65536, 32'sd0, 16'sd0};        rows.push_back(row);
      row.pose = '{-32'sd65536, 32'sd0, 16'sd0};       rows.push_back(row);
      row.pose = '{32'sd0, 32'sd65536, 16'sd0};        rows.push_back(row);
      row.pose = '{32'sd0, -32'sd65536, 16'sd0};       rows.push_back(row);
      row.pose = '{32'h7fffffff, 32'h7fffffff, 16'sd25736};    rows.push_back(row);
      row.pose = '{32'h80000000, 32'h80000000, -16'sd25736};   rows.push_back(row);
      row.pose = '{32'h80000000, 32'h7fffffff, 16'h7fff};      rows.push_back(row);
      row.pose = '{32'h7fffffff, 32'h80000000, 16'h8000};      rows.push_back(row);
      row.pose = '{32'sd1, 32'sd0, 16'sd0};            rows.push_back(row);
      row.pose = '{32'sd0, 32'sd0, 16'sd25736};        rows.push_back(row);
      row.pose = '{32'sd3, 32'sd3, -16'sd25735};       rows.push_back(row);
      row.pose = '{-32'sd327680, 32'sd0, 16'sd8000};   rows.push_back(row);
      row.pose = '{-32'sd327680, 32'sd0, 16'sd0};      rows.push_back(row);
      row.pose = '{32'sd200000, -32'sd100000, 16'sd1300}; rows.push_back(row);
      foreach (rows[i]) send_pose(rows[i]);
      wait_idle();

      row.typed = 1'b0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_TARGET_X, 32'h7fffffff);
               write_reg(REG_TARGET_Y, 32'h7fffffff);
               write_reg(REG_TARGET_H, 32'sd25736);
               write_reg(REG_GAIN_DIST, 32'hffff);
               write_reg(REG_GAIN_BEAR, 32'hffff);
               write_reg(REG_GAIN_FIN, 32'hffff);
               write_reg(REG_THRESHOLD, 32'd0);
            end
            1: begin
               write_reg(REG_TARGET_X, 32'h80000000);
               write_reg(REG_TARGET_Y, 32'h80000000);
               write_reg(REG_TARGET_H, -32'sd25736);
               write_reg(REG_GAIN_DIST, 32'd0);
               write_reg(REG_GAIN_BEAR, 32'd0);
               write_reg(REG_GAIN_FIN, 32'd0);
               write_reg(REG_THRESHOLD, 32'hffffffff);
            end
            default: begin
               thr = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 70000);
               write_reg(REG_TARGET_X, $urandom());
               write_reg(REG_TARGET_Y, $urandom());
               write_reg(REG_TARGET_H, $urandom_range(0, 51472) - 25736);
               write_reg(REG_GAIN_DIST, $urandom_range(0, 65535));
               write_reg(REG_GAIN_BEAR, $urandom_range(0, 65535));
               write_reg(REG_GAIN_FIN, $urandom_range(0, 65535));
               write_reg(REG_THRESHOLD, thr);
            end
         endcase
         for (int n = 0; n < 105; n++) begin
            // A write to the unused index must neither change nor re-arm anything.
            if (n == 52 && phase % 3 == 2) begin
               wait_idle();
               write_reg(REG_UNUSED, $urandom());
            end
            row.pose = rand_pose(phase);
            send_pose(row);
         end
         wait_idle();
      end

      if (fail_count == 0 && drive_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Receiver stalls come in bursts, with stretches of steady acceptance.
   initial begin
      rsp_ready = 1'b0;
      rx_steady = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) rx_steady = ~rx_steady;
         if (rx_steady) rsp_ready = 1'b1;
         else if (!rsp_ready && $urandom_range(0, 99) < 2)
            rsp_ready = 1'b0;
         else
            rsp_ready = ($urandom_range(0, 99) < 70);
         if (!rx_steady && $urandom_range(0, 199) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(20, 150)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (drive_queue.size() == 0) begin
               $display("%0t: expected no word, got %p", $realtime, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = drive_queue.pop_front();
               if (rsp_data.drive_one !== want.drive_one
                     || rsp_data.drive_two !== want.drive_two
                     || rsp_data.arrived !== want.arrived) begin
                  $display("%0t: expected %0d %0d %0b, got %0d %0d %0b", $realtime,
                           want.drive_one, want.drive_two, want.arrived,
                           rsp_data.drive_one, rsp_data.drive_two, rsp_data.arrived);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: sim.f
src/gtp_pkg.sv
src/gtp_cordic.sv
src/gtp_isqrt.sv
src/go_to_pose_drive_controller_core.sv
verif/tb_go_to_pose_drive_controller_core.sv
